// ===== rtl/core/jksae_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jksae_pkg: shared types and codes for the JSON key string array extractor
// Result item layout, per-byte result group, phase and status codes.
// ----------------------------------------------------------------------------
package jksae_pkg;

  localparam int unsigned KeyLen   = 20;
  localparam int unsigned MaxItems = 3;

  // key text "compileDiagnostics", quotes included, first byte at index 0
  localparam logic [7:0] KEY_TEXT [KeyLen] = '{
    8'h22, 8'h63, 8'h6F, 8'h6D, 8'h70, 8'h69, 8'h6C, 8'h65, 8'h44, 8'h69,
    8'h61, 8'h67, 8'h6E, 8'h6F, 8'h73, 8'h74, 8'h69, 8'h63, 8'h73, 8'h22
  };

  // parser phases
  localparam logic [3:0] PH_SEARCH  = 4'd0;
  localparam logic [3:0] PH_COLON   = 4'd1;
  localparam logic [3:0] PH_BRACKET = 4'd2;
  localparam logic [3:0] PH_VALUE   = 4'd3;
  localparam logic [3:0] PH_STRING  = 4'd4;
  localparam logic [3:0] PH_ESCAPE  = 4'd5;
  localparam logic [3:0] PH_HEX     = 4'd6;
  localparam logic [3:0] PH_SEP     = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  // section status
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK  = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  // all results of one input byte
  typedef struct packed {
    logic [1:0]              cnt;
    out_item_t [MaxItems-1:0] item;
  } grp_t;

endpackage

// ===== rtl/core/jksae_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jksae_in_if / jksae_out_if: valid/ready channels of the extractor
// Input carries text bytes, output carries decoded result items.
// ----------------------------------------------------------------------------
interface jksae_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface jksae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  output status, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  input status, input last_of_run, output ready);
endinterface

// ===== rtl/core/jksae_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jksae_parser: per-byte parser step
// Holds key window, phase and \u state; builds the result group of one byte.
// ----------------------------------------------------------------------------
module jksae_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  jksae_pkg::in_item_t item_i,
  output jksae_pkg::grp_t    grp_o
);

  localparam int unsigned WinLen = jksae_pkg::KeyLen - 1;

  logic [7:0]  win_q [WinLen];
  logic [7:0]  win_d [WinLen];
  logic [3:0]  ph_q, ph_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [15:0] acc_q, acc_d;

  logic [7:0]  b;
  logic        key_hit;
  logic        sp;
  logic        hex_ok;
  logic [3:0]  hex_v;
  logic [15:0] acc_new;
  logic [1:0]  status;
  logic [1:0]  n;
  logic [1:0]  nb;
  logic [7:0]  ob [jksae_pkg::MaxItems];
  logic        done_flag;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
  endfunction

  assign b  = item_i.data_byte;
  assign sp = is_space(b);

  always_comb begin
    key_hit = (b == jksae_pkg::KEY_TEXT[jksae_pkg::KeyLen-1]);
    for (int i = 0; i < WinLen; i++) begin
      if (win_q[i] != jksae_pkg::KEY_TEXT[i]) key_hit = 1'b0;
    end
  end

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) hex_v = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) hex_v = 4'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) hex_v = 4'(b - 8'h37);
    else hex_ok = 1'b0;
  end

  assign acc_new = {acc_q[11:0], hex_v};

  always_comb begin
    ph_d      = ph_q;
    hcnt_d    = hcnt_q;
    acc_d     = acc_q;
    status    = jksae_pkg::ST_RUN;
    n         = 2'd0;
    done_flag = 1'b0;
    for (int i = 0; i < int'(jksae_pkg::MaxItems); i++) ob[i] = 8'h00;
    for (int i = 0; i < WinLen; i++) win_d[i] = win_q[i];

    unique case (ph_q)
      jksae_pkg::PH_SEARCH: begin
        for (int i = 0; i < WinLen - 1; i++) win_d[i] = win_q[i+1];
        win_d[WinLen-1] = b;
        if (key_hit) ph_d = jksae_pkg::PH_COLON;
      end
      jksae_pkg::PH_COLON: begin
        if (!sp) begin
          if (b == 8'h3A) ph_d = jksae_pkg::PH_BRACKET;
          else status = jksae_pkg::ST_BAD;
        end
      end
      jksae_pkg::PH_BRACKET: begin
        if (!sp) begin
          if (b == 8'h5B) ph_d = jksae_pkg::PH_VALUE;
          else status = jksae_pkg::ST_BAD;
        end
      end
      jksae_pkg::PH_VALUE: begin
        if (!sp) begin
          if (b == 8'h5D) status = jksae_pkg::ST_OK;
          else if (b == 8'h22) ph_d = jksae_pkg::PH_STRING;
          else status = jksae_pkg::ST_BAD;
        end
      end
      jksae_pkg::PH_STRING: begin
        if (b == 8'h22) begin
          n         = 2'd1;
          done_flag = 1'b1;
          ph_d      = jksae_pkg::PH_SEP;
        end else if (b == 8'h5C) begin
          ph_d = jksae_pkg::PH_ESCAPE;
        end else begin
          n     = 2'd1;
          ob[0] = b;
        end
      end
      jksae_pkg::PH_ESCAPE: begin
        ph_d = jksae_pkg::PH_STRING;
        if (b == 8'h22 || b == 8'h5C) begin
          n = 2'd1; ob[0] = b;
        end else if (b == 8'h6E) begin
          n = 2'd1; ob[0] = 8'h0A;
        end else if (b == 8'h72) begin
          n = 2'd1; ob[0] = 8'h0D;
        end else if (b == 8'h74) begin
          n = 2'd1; ob[0] = 8'h09;
        end else if (b == 8'h75) begin
          ph_d   = jksae_pkg::PH_HEX;
          hcnt_d = 2'd0;
          acc_d  = 16'h0000;
        end else begin
          status = jksae_pkg::ST_BAD;
        end
      end
      jksae_pkg::PH_HEX: begin
        if (!hex_ok) begin
          status = jksae_pkg::ST_BAD;
        end else if (hcnt_q == 2'd3) begin
          // code point to UTF-8
          if (acc_new < 16'h0080) begin
            n     = 2'd1;
            ob[0] = acc_new[7:0];
          end else if (acc_new < 16'h0800) begin
            n     = 2'd2;
            ob[0] = {3'b110, acc_new[10:6]};
            ob[1] = {2'b10, acc_new[5:0]};
          end else begin
            n     = 2'd3;
            ob[0] = {4'b1110, acc_new[15:12]};
            ob[1] = {2'b10, acc_new[11:6]};
            ob[2] = {2'b10, acc_new[5:0]};
          end
          hcnt_d = 2'd0;
          acc_d  = 16'h0000;
          ph_d   = jksae_pkg::PH_STRING;
        end else begin
          acc_d  = acc_new;
          hcnt_d = hcnt_q + 2'd1;
        end
      end
      jksae_pkg::PH_SEP: begin
        if (!sp) begin
          if (b == 8'h2C) ph_d = jksae_pkg::PH_VALUE;
          else if (b == 8'h5D) status = jksae_pkg::ST_OK;
          else status = jksae_pkg::ST_BAD;
        end
      end
      default: begin
      end
    endcase

    if (status != jksae_pkg::ST_RUN) ph_d = jksae_pkg::PH_DONE;

    if (item_i.buffer_end) begin
      if (ph_d == jksae_pkg::PH_SEARCH) status = jksae_pkg::ST_OK;
      else if (ph_d != jksae_pkg::PH_DONE) status = jksae_pkg::ST_BAD;
      ph_d   = jksae_pkg::PH_SEARCH;
      hcnt_d = 2'd0;
      acc_d  = 16'h0000;
      for (int i = 0; i < WinLen; i++) win_d[i] = 8'h00;
    end

    // decoded bytes only; the closing-quote item carries none
    nb = done_flag ? 2'd0 : n;

    // status-only step still needs one carrier item
    if (status != jksae_pkg::ST_RUN && n == 2'd0) n = 2'd1;
  end

  always_comb begin
    grp_o.cnt = n;
    for (int i = 0; i < int'(jksae_pkg::MaxItems); i++) begin
      grp_o.item[i].out_byte    = ob[i];
      grp_o.item[i].byte_valid  = (2'(i) < nb);
      grp_o.item[i].string_done = (i == 0) && done_flag;
      grp_o.item[i].last_of_run = (2'(i) == n - 2'd1);
      grp_o.item[i].status      = (2'(i) == n - 2'd1) ? status : jksae_pkg::ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= jksae_pkg::PH_SEARCH;
      hcnt_q <= 2'd0;
      acc_q  <= 16'h0000;
      for (int i = 0; i < WinLen; i++) win_q[i] <= 8'h00;
    end else if (step_i) begin
      ph_q   <= ph_d;
      hcnt_q <= hcnt_d;
      acc_q  <= acc_d;
      for (int i = 0; i < WinLen; i++) win_q[i] <= win_d[i];
    end
  end

endmodule

// ===== rtl/core/jksae_outbuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jksae_outbuf: result group register
// Holds the items of one byte and hands them out one per transaction.
// ----------------------------------------------------------------------------
module jksae_outbuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  jksae_pkg::grp_t grp_i,
  output logic            free_o,
  jksae_out_if.source     out_o
);

  logic [1:0]                               cnt_q, cnt_d;
  logic [1:0]                               idx_q, idx_d;
  jksae_pkg::out_item_t [jksae_pkg::MaxItems-1:0] items_q;
  jksae_pkg::out_item_t                     cur;
  logic                                     out_fire;
  logic                                     at_last;

  assign out_fire = out_o.valid && out_o.ready;
  assign at_last  = (idx_q == cnt_q - 2'd1);
  assign free_o   = (cnt_q == 2'd0) || (out_fire && at_last);

  always_comb begin
    case (idx_q)
      2'd0:    cur = items_q[0];
      2'd1:    cur = items_q[1];
      default: cur = items_q[2];
    endcase
  end

  assign out_o.valid       = (cnt_q != 2'd0);
  assign out_o.out_byte    = cur.out_byte;
  assign out_o.byte_valid  = cur.byte_valid;
  assign out_o.string_done = cur.string_done;
  assign out_o.status      = cur.status;
  assign out_o.last_of_run = cur.last_of_run;

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (out_fire) begin
      if (at_last) begin
        cnt_d = 2'd0;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      cnt_d = grp_i.cnt;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) items_q <= grp_i.item;
  end

endmodule

// ===== rtl/core/json_key_string_array_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_key_string_array_extractor_unit: JSON string array extractor
// Finds the quoted key "compileDiagnostics" in a byte stream, then decodes
// the string array after it into a stream of unescaped bytes.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                                          | per transaction
//  --------+-----+--------------------------------------------------+----------------
//  in_i    | in  | data_byte, buffer_end                            | one text byte
//  out_o   | out | out_byte, byte_valid, string_done, status, last  | one result item
//
//  One text byte per cycle enters the input register while it is free. The parser
//  step runs in the cycle the byte leaves that register for the result group
//  register, which hands out the first item. A byte with one result or none
//  sustains one byte per cycle while the output is ready; a \u escape that expands
//  to two or three UTF-8 bytes holds the input while the group drains.
//  Reset clears the phase, the key window and the \u state; no clearing pass.
//  Output stalls hold the group register and back up into the input register.
//
module json_key_string_array_extractor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  jksae_in_if.sink    in_i,
  jksae_out_if.source out_o
);

  // input register
  logic                 in_vld_q;
  jksae_pkg::in_item_t  in_q;
  logic                 in_fire;

  // parser step handoff
  logic                 take;
  logic                 grp_free;
  jksae_pkg::grp_t      grp;

  assign in_i.ready = !in_vld_q || take;
  assign in_fire    = in_i.valid && in_i.ready;

  // step fires when the result group register can take a new group
  assign take = in_vld_q && grp_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (take) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.data_byte  <= in_i.data_byte;
      in_q.buffer_end <= in_i.buffer_end;
    end
  end

  jksae_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (take),
    .item_i (in_q),
    .grp_o  (grp)
  );

  // bytes with no result only advance parser state
  jksae_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && (grp.cnt != 2'd0)),
    .grp_i  (grp),
    .free_o (grp_free),
    .out_o  (out_o)
  );

endmodule

// ===== rtl/core/jksae_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jksae_checker: port-level checks on the result channel
// Bound to the extractor top level.
// ----------------------------------------------------------------------------
module jksae_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [7:0] out_byte_i,
  input logic       byte_valid_i,
  input logic       string_done_i,
  input logic [1:0] status_i,
  input logic       last_of_run_i
);

  // stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(out_byte_i) && $stable(status_i)
      && $stable(last_of_run_i))
    else $error("stalled result item changed");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !byte_valid_i |-> out_byte_i == 8'h00)
    else $error("out_byte nonzero without byte_valid");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && status_i != jksae_pkg::ST_RUN |-> last_of_run_i)
    else $error("status on item that is not last of run");

  a_done_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && string_done_i |-> !byte_valid_i)
    else $error("string_done together with a data byte");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> status_i == jksae_pkg::ST_RUN || status_i == jksae_pkg::ST_OK
      || status_i == jksae_pkg::ST_BAD)
    else $error("undefined status code");

endmodule

bind json_key_string_array_extractor_unit jksae_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .byte_valid_i  (out_o.byte_valid),
  .string_done_i (out_o.string_done),
  .status_i      (out_o.status),
  .last_of_run_i (out_o.last_of_run)
);
